FILE: src/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int LINES    = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * LINES;

    localparam int COL_W  = 7;
    localparam int LINE_W = 5;
    localparam int ADDR_W = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int MODE_W = 2;
    localparam int OP_W   = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_ATTR = '0;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  target_column;
        logic [LINE_W-1:0] target_line;
    } req_t;

    typedef struct packed {
        logic [COL_W-1:0]  column_now;
        logic [LINE_W-1:0] line_now;
        logic [ADDR_W-1:0] cursor_offset;
        logic              cell_touched;
        logic [ADDR_W-1:0] cell_address;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } res_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              scroll;
        logic [ATTR_W-1:0] attr;
        res_t              res;
    } cmd_t;

endpackage

FILE: src/text_console_char_writer.sv
// channel   direction  handshake                       payload
// request   in         start && !busy                  req (tcw_pkg::req_t)
// result    out        done, one cycle, no hold-off    res (tcw_pkg::res_t)
// config    in         apb psel&penable&pwrite&!paddr[2]  pwdata[7:0] -> text attribute
//
// put, move or no-op: the request is queued, popped in B_IDLE and its result registered; read cell: also via B_READ
// scroll: copy of 1920 cells then 80-cell bottom fill, one cell a cycle
// clear screen: one cell a cycle through the single write port
// after reset busy stays high while the cell store is filled with blanks
// the next request is taken in the cycle its predecessor's result is shown
module text_console_char_writer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tcw_pkg::req_t                req,
    output logic                         done,
    output tcw_pkg::res_t                res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              cfg_wr;
    logic              attr_sel;
    logic              back_idle;
    logic              q_empty;
    logic              push;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              head;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[PADDR_W-1:2] == REG_ATTR);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = attr_sel ? PDATA_W'(attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (cfg_wr && attr_sel)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .attr      (attr_reg),
        .back_idle (back_idle),
        .q_empty   (q_empty),
        .busy      (busy),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tcw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    tcw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .idle    (back_idle),
        .done    (done),
        .res     (res)
    );

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request not held off while in flight");

endmodule

FILE: src/tcw_fifo.sv
module tcw_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tcw_pkg::cmd_t head,
    output logic          empty
);
    import tcw_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != (Q_PTR_W + 1)'(Q_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

FILE: src/tcw_front.sv
module tcw_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  tcw_pkg::req_t            req,
    input  logic [tcw_pkg::ATTR_W-1:0] attr,
    input  logic                     back_idle,
    input  logic                     q_empty,
    output logic                     busy,
    output logic                     push,
    output tcw_pkg::cmd_t            push_cmd
);
    import tcw_pkg::*;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [COL_W:0]    col_x;
    logic [LINE_W:0]   line_x;
    logic [COL_W-1:0]  tgt_col;
    logic [LINE_W-1:0] tgt_line;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] tgt_addr;

    assign busy = !back_idle || !q_empty;
    assign push = start && !busy;

    assign tgt_col  = (req.target_column > COL_W'(COLUMNS - 1)) ?
                      COL_W'(COLUMNS - 1) : req.target_column;
    assign tgt_line = (req.target_line > LINE_W'(LINES - 1)) ?
                      LINE_W'(LINES - 1) : req.target_line;
    assign cur_addr = ADDR_W'(int'(line_reg) * COLUMNS + int'(col_reg));
    assign tgt_addr = ADDR_W'(int'(tgt_line) * COLUMNS + int'(tgt_col));

    always_comb
    begin
        col_x    = {1'b0, col_reg};
        line_x   = {1'b0, line_reg};
        push_cmd = '0;
        push_cmd.op   = OP_NONE;
        push_cmd.attr = attr;
        unique case (req.mode)
            MODE_PUT:
            begin
                unique case (req.char_code)
                    CH_CR:
                    begin
                        col_x = '0;
                    end
                    CH_TAB:
                    begin
                        col_x = (COL_W + 1)'((int'(col_reg) / TAB_STOP + 1) * TAB_STOP);
                    end
                    CH_LF:
                    begin
                        col_x  = '0;
                        line_x = line_x + 1'b1;
                    end
                    CH_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_x = col_x - 1'b1;
                        end
                    end
                    default:
                    begin
                        if (req.char_code >= CH_BLANK)
                        begin
                            push_cmd.op               = OP_WRITE;
                            push_cmd.res.cell_touched = 1'b1;
                            push_cmd.res.cell_address = cur_addr;
                            push_cmd.res.cell_value   = {attr, req.char_code};
                            col_x = col_x + 1'b1;
                        end
                    end
                endcase
                if (col_x >= (COL_W + 1)'(COLUMNS))
                begin
                    col_x  = '0;
                    line_x = line_x + 1'b1;
                end
                if (line_x >= (LINE_W + 1)'(LINES))
                begin
                    line_x          = (LINE_W + 1)'(LINES - 1);
                    push_cmd.scroll = 1'b1;
                    push_cmd.res.scrolled = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
                col_x  = '0;
                line_x = '0;
            end
            MODE_MOVE:
            begin
                col_x  = {1'b0, tgt_col};
                line_x = {1'b0, tgt_line};
            end
            MODE_READ:
            begin
                push_cmd.op               = OP_READ;
                push_cmd.res.cell_touched = 1'b1;
                push_cmd.res.cell_address = tgt_addr;
            end
            default:
            begin
                push_cmd.op = OP_NONE;
            end
        endcase
        col_next  = col_x[COL_W-1:0];
        line_next = line_x[LINE_W-1:0];
        push_cmd.res.column_now    = col_next;
        push_cmd.res.line_now      = line_next;
        push_cmd.res.cursor_offset = ADDR_W'(int'(line_next) * COLUMNS + int'(col_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (push)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

FILE: src/tcw_back.sv
module tcw_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tcw_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          idle,
    output logic          done,
    output tcw_pkg::res_t res
);
    import tcw_pkg::*;

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_READ = 3'd2;
    localparam logic [2:0] B_COPY = 3'd3;
    localparam logic [2:0] B_TAIL = 3'd4;
    localparam logic [2:0] B_FILL = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLUMNS);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              done_reg;
    logic              done_next;
    res_t              res_reg;
    res_t              res_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] blank;

    assign idle  = (state_reg == B_IDLE);
    assign done  = done_reg;
    assign res   = res_reg;
    assign blank = {cmd_reg.attr, CH_BLANK};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg;
        mem_wdata  = blank;
        mem_re     = 1'b0;
        mem_raddr  = cnt_reg + ADDR_W'(COLUMNS);
        unique case (state_reg)
            B_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = B_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    cnt_next = '0;
                    if (head.op == OP_READ)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head.res.cell_address;
                        state_next = B_READ;
                    end
                    else if (head.op == OP_CLEAR)
                    begin
                        state_next = B_FILL;
                    end
                    else
                    begin
                        if (head.op == OP_WRITE)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = head.res.cell_address;
                            mem_wdata = head.res.cell_value;
                        end
                        if (head.scroll)
                        begin
                            state_next = B_COPY;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            res_next  = head.res;
                        end
                    end
                end
            end
            B_READ:
            begin
                done_next           = 1'b1;
                res_next            = cmd_reg.res;
                res_next.cell_value = rdata_reg;
                state_next          = B_IDLE;
            end
            B_COPY:
            begin
                mem_re    = 1'b1;
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = rdata_reg;
                mem_we    = (cnt_reg != '0);
                if (cnt_reg == LAST_COPY)
                begin
                    state_next = B_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_TAIL:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rdata_reg;
                cnt_next   = BOTTOM;
                state_next = B_FILL;
            end
            B_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    done_next  = 1'b1;
                    res_next   = cmd_reg.res;
                    state_next = B_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != B_INIT)
        else $error("result during power-up clear");

    a_copy_only_on_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_COPY |-> cmd_reg.scroll && cnt_reg <= LAST_COPY)
        else $error("copy sweep without scroll or past range");

endmodule
